### sv/assert_macros.svh
// Assertion macros shared by the maze builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MDB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define MDB_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MDB_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MDB_ASSERT(name, clk, rst, prop)
`define MDB_ASSERT_IMP(name, clk, rst, ante, cons)
`define MDB_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### sv/mdb_pkg.sv
// Types, codes and constants of the maze builder.
`timescale 1ns / 1ps
package mdb_pkg;

   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_TRACE = 3'd2;
   localparam logic [2:0] KIND_CLEAR = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SEED = 2'd2;

   localparam logic [5:0]  WIDTH_RESET  = 6'd30;
   localparam logic [5:0]  HEIGHT_RESET = 6'd20;
   localparam logic [15:0] SEED_RESET   = 16'd44257;
   localparam logic [15:0] LFSR_MASK    = 16'hB400;

   localparam logic [3:0] F_VISITED = 4'h1;
   localparam logic [3:0] F_EAST    = 4'h2;
   localparam logic [3:0] F_SOUTH   = 4'h4;
   localparam logic [3:0] F_TRACE   = 4'h8;

   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_W = 2'd1;
   localparam logic [1:0] DIR_E = 2'd2;
   localparam logic [1:0] DIR_S = 2'd3;

   localparam int DIV_NW = 16;
   localparam int DIV_DW = 7;

   typedef struct packed {
      logic [2:0] kind;
      logic [9:0] cell_index;
   } req_type;

   typedef struct packed {
      logic       carved_valid;
      logic [9:0] carved_cell;
      logic       popped;
      logic       finished;
      logic       trace_valid;
      logic [9:0] trace_cell;
      logic [3:0] cell_flags;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              busy;
      logic [DIV_NW-1:0] quotient;
      logic [DIV_DW-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_SEED,
      ST_TOP_RD,
      ST_TOP_CHK,
      ST_DIV_POS,
      ST_NB_RD,
      ST_NB_CAP,
      ST_SELECT,
      ST_DIV_PICK,
      ST_CARVE,
      ST_WALL,
      ST_TR_RD,
      ST_TR_PAR,
      ST_TR_MARK,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_ITEM_CAP,
      ST_RESP
   } state_type;

   function automatic logic [15:0] lfsr_next(input logic [15:0] s);
      logic [15:0] n;
      n = {1'b0, s[15:1]};
      if (s[0]) begin
         n = n ^ LFSR_MASK;
      end
      return n;
   endfunction

endpackage

### sv/mdb_div.sv
// Bit-serial restoring divider shared for cell position and neighbor choice.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mdb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mdb_pkg::div_req_type div_req,
   output mdb_pkg::div_rsp_type div_rsp
);
   import mdb_pkg::*;

   localparam int SW = $clog2(DIV_NW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] dsr_ff, dsr_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NW-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         step_in = SW'(DIV_NW - 1);
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_NW-2:0], fits};
         rem_in  = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         step_in = step_ff - SW'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   always_comb begin
      div_rsp.done      = done_ff;
      div_rsp.busy      = busy_ff;
      div_rsp.quotient  = quo_ff;
      div_rsp.remainder = rem_ff;
   end

   `MDB_ASSERT_IMP(a_div_no_restart, clock, reset, div_req.start, !busy_ff)
   `MDB_ASSERT_IMP(a_div_done_idle, clock, reset, done_ff, !busy_ff)
   `MDB_ASSERT_NXT(a_div_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

### sv/maze_dfs_backtracker_core.sv
// Top level of the randomized depth-first maze builder.
//
// Items enter on req_data and are taken at a clock edge where start is high
// and busy is low. Each item gives exactly one result on rsp_data, shown for
// one cycle with rsp_strobe high; the receiver cannot hold it off. Registers
// are written through csr_we, csr_index and csr_wdata; the user must write
// them only while busy is low, as the block itself does not enforce it. Cell
// flags, parents and the walk stack sit in three memories with one read and
// one write port each; a shared bit-serial divider finds the row and column
// of the stack top and the neighbor number r mod n. A tick runs up to two
// divider passes, five cell reads and the trace step; a start sweeps every
// cell, and a trace clear reads and rewrites every cell.
// One item is in flight at a time; busy stays high until its result is out.
// After reset a clearing pass over all NCELLS cells (1024 at the default size)
// runs with busy high; configuration writes are taken during it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module maze_dfs_backtracker_core #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mdb_pkg::req_type                req_data,
   output logic                            rsp_strobe,
   output mdb_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [mdb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mdb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mdb_pkg::*;

   localparam int NCELLS = MAX_COLS * MAX_ROWS;
   localparam int CW     = $clog2(NCELLS);
   localparam int NW     = $clog2(NCELLS + 1);
   localparam int WW     = $clog2(MAX_COLS + 1);
   localparam int HW     = $clog2(MAX_ROWS + 1);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CLW    = $clog2(MAX_COLS);
   localparam int PW     = CW + 1;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]    kind_ff, kind_in;
   logic [9:0]    idx_ff, idx_in;
   logic [WW-1:0] geo_w_ff, geo_w_in;
   logic [HW-1:0] geo_h_ff, geo_h_in;
   logic [NW-1:0] cells_ff, cells_in;
   logic [NW-1:0] depth_ff, depth_in;
   logic [NW-1:0] visited_ff, visited_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic          cursor_vld_ff, cursor_vld_in;
   logic [15:0]   lfsr_ff, lfsr_in;
   logic [CW-1:0] top_ff, top_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CLW-1:0] col_ff, col_in;
   logic [3:0]    cand_ff, cand_in;
   logic [3:0]    nbf_ff [5];
   logic [3:0]    nbf_in [5];
   logic [1:0]    dir_ff, dir_in;
   logic [2:0]    slot_ff, slot_in;
   rsp_type       res_ff, res_in;
   logic [5:0]    width_ff;
   logic [5:0]    height_ff;
   logic [15:0]   seed_ff;

   logic [3:0]    cell_mem [NCELLS];
   logic [PW-1:0] par_mem [NCELLS];
   logic [CW-1:0] stk_mem [NCELLS];
   logic [3:0]    cell_rd_ff;
   logic [PW-1:0] par_rd_ff;
   logic [CW-1:0] stk_rd_ff;

   logic          cell_we, par_we, stk_we;
   logic [CW-1:0] cell_raddr, cell_waddr, par_raddr, par_waddr, stk_raddr, stk_waddr;
   logic [3:0]    cell_wdata;
   logic [PW-1:0] par_wdata;
   logic [CW-1:0] stk_wdata;

   logic [WW-1:0] geo_w_c;
   logic [HW-1:0] geo_h_c;
   logic [NW-1:0] cells_c;
   logic          accept;
   logic          idx_ok;
   logic [CW-1:0] addr_n, addr_w, addr_e, addr_s, slot_addr, nb_addr;
   logic [3:0]    exists;
   logic [3:0]    cand_c;
   logic [2:0]    cand_n;
   logic [1:0]    pick_dir;
   logic [2:0]    seen;
   logic          pick_hit;
   logic [15:0]   lfsr_step;

   div_req_type   div_req;
   div_rsp_type   div_rsp;

   mdb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         seed_ff   <= SEED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAZE_WIDTH: begin
               width_ff <= csr_wdata[5:0];
            end
            CSR_MAZE_HEIGHT: begin
               height_ff <= csr_wdata[5:0];
            end
            CSR_RANDOM_SEED: begin
               seed_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff < 6'd2) begin
         geo_w_c = WW'(2);
      end else if (32'(width_ff) > MAX_COLS) begin
         geo_w_c = WW'(MAX_COLS);
      end else begin
         geo_w_c = WW'(width_ff);
      end
      if (height_ff < 6'd2) begin
         geo_h_c = HW'(2);
      end else if (32'(height_ff) > MAX_ROWS) begin
         geo_h_c = HW'(MAX_ROWS);
      end else begin
         geo_h_c = HW'(height_ff);
      end
      cells_c = NW'(geo_w_c * geo_h_c);
   end

   always_comb begin
      addr_n    = top_ff - CW'(geo_w_ff);
      addr_w    = top_ff - CW'(1);
      addr_e    = top_ff + CW'(1);
      addr_s    = top_ff + CW'(geo_w_ff);
      exists[0] = row_ff != '0;
      exists[1] = col_ff != '0;
      exists[2] = (WW'(col_ff) + WW'(1)) < geo_w_ff;
      exists[3] = (HW'(row_ff) + HW'(1)) < geo_h_ff;
      for (int i = 0; i < 4; i++) begin
         cand_c[i] = exists[i] && !nbf_ff[i + 1][0];
      end
      cand_n    = 3'($countones(cand_c));
      lfsr_step = lfsr_next(lfsr_ff);
      case (slot_ff)
         3'd1:    slot_addr = addr_n;
         3'd2:    slot_addr = addr_w;
         3'd3:    slot_addr = addr_e;
         3'd4:    slot_addr = addr_s;
         default: slot_addr = top_ff;
      endcase
      case (dir_ff)
         DIR_N:   nb_addr = addr_n;
         DIR_W:   nb_addr = addr_w;
         DIR_E:   nb_addr = addr_e;
         default: nb_addr = addr_s;
      endcase
      pick_dir = DIR_N;
      pick_hit = 1'b0;
      seen     = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_ff[i] && !pick_hit) begin
            if (seen == {1'b0, div_rsp.remainder[1:0]}) begin
               pick_dir = 2'(i);
               pick_hit = 1'b1;
            end
            seen = seen + 3'd1;
         end
      end
   end

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = state_ff != ST_IDLE;
   assign idx_ok = 32'(idx_ff) < 32'(cells_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      geo_w_in      = geo_w_ff;
      geo_h_in      = geo_h_ff;
      cells_in      = cells_ff;
      depth_in      = depth_ff;
      visited_in    = visited_ff;
      cursor_in     = cursor_ff;
      cursor_vld_in = cursor_vld_ff;
      lfsr_in       = lfsr_ff;
      top_in        = top_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cand_in       = cand_ff;
      nbf_in        = nbf_ff;
      dir_in        = dir_ff;
      slot_in       = slot_ff;
      res_in        = res_ff;
      cell_we       = 1'b0;
      cell_raddr    = cnt_ff;
      cell_waddr    = cnt_ff;
      cell_wdata    = '0;
      par_we        = 1'b0;
      par_raddr     = cursor_ff;
      par_waddr     = cnt_ff;
      par_wdata     = '0;
      stk_we        = 1'b0;
      stk_raddr     = CW'(depth_ff - NW'(1));
      stk_waddr     = CW'(depth_ff);
      stk_wdata     = nb_addr;
      div_req       = '0;
      case (state_ff)
         ST_INIT, ST_SWEEP: begin
            cell_we = 1'b1;
            par_we  = 1'b1;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NCELLS - 1)) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_SEED;
            end
         end
         ST_IDLE: begin
            cell_raddr = CW'(req_data.cell_index);
            if (accept) begin
               kind_in  = req_data.kind;
               idx_in   = req_data.cell_index;
               geo_w_in = geo_w_c;
               geo_h_in = geo_h_c;
               cells_in = cells_c;
               res_in   = '0;
               cnt_in   = '0;
               case (req_data.kind)
                  KIND_TICK: begin
                     if (visited_ff < cells_c && depth_ff != '0) begin
                        state_in = ST_TOP_RD;
                     end else begin
                        state_in = ST_TR_RD;
                     end
                  end
                  KIND_START: begin
                     state_in = ST_SWEEP;
                  end
                  KIND_TRACE, KIND_READ: begin
                     if (32'(req_data.cell_index) < 32'(cells_c)) begin
                        state_in = ST_ITEM_CAP;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  KIND_CLEAR: begin
                     state_in = ST_CLR_RD;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SEED: begin
            lfsr_in       = (seed_ff == '0) ? 16'd1 : seed_ff;
            depth_in      = '0;
            visited_in    = '0;
            cursor_vld_in = 1'b0;
            stk_waddr     = '0;
            stk_wdata     = CW'(idx_ff);
            cell_waddr    = CW'(idx_ff);
            cell_wdata    = F_VISITED;
            if (idx_ok) begin
               stk_we     = 1'b1;
               cell_we    = 1'b1;
               depth_in   = NW'(1);
               visited_in = NW'(1);
            end
            state_in = ST_RESP;
         end
         ST_TOP_RD: begin
            state_in = ST_TOP_CHK;
         end
         ST_TOP_CHK: begin
            top_in = stk_rd_ff;
            if (NW'(stk_rd_ff) >= cells_ff) begin
               depth_in      = depth_ff - NW'(1);
               res_in.popped = 1'b1;
               state_in      = ST_TR_RD;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NW'(stk_rd_ff);
               div_req.divisor  = DIV_DW'(geo_w_ff);
               state_in         = ST_DIV_POS;
            end
         end
         ST_DIV_POS: begin
            if (div_rsp.done) begin
               row_in   = RW'(div_rsp.quotient);
               col_in   = CLW'(div_rsp.remainder);
               slot_in  = '0;
               state_in = ST_NB_RD;
            end
         end
         ST_NB_RD: begin
            cell_raddr = slot_addr;
            state_in   = ST_NB_CAP;
         end
         ST_NB_CAP: begin
            nbf_in[slot_ff] = cell_rd_ff;
            slot_in         = slot_ff + 3'd1;
            state_in        = (slot_ff == 3'd4) ? ST_SELECT : ST_NB_RD;
         end
         ST_SELECT: begin
            if (cand_n != '0 && 32'(depth_ff) < NCELLS) begin
               lfsr_in          = lfsr_step;
               cand_in          = cand_c;
               div_req.start    = 1'b1;
               div_req.dividend = lfsr_step;
               div_req.divisor  = DIV_DW'(cand_n);
               state_in         = ST_DIV_PICK;
            end else begin
               depth_in      = depth_ff - NW'(1);
               res_in.popped = 1'b1;
               state_in      = ST_TR_RD;
            end
         end
         ST_DIV_PICK: begin
            if (div_rsp.done) begin
               dir_in   = pick_dir;
               state_in = ST_CARVE;
            end
         end
         ST_CARVE: begin
            cell_we    = 1'b1;
            cell_waddr = nb_addr;
            cell_wdata = nbf_ff[dir_ff + 3'd1] | F_VISITED
                       | ((dir_ff == DIR_W) ? F_EAST : 4'h0)
                       | ((dir_ff == DIR_N) ? F_SOUTH : 4'h0);
            par_we     = 1'b1;
            par_waddr  = nb_addr;
            par_wdata  = {1'b1, top_ff};
            stk_we     = 1'b1;
            depth_in   = depth_ff + NW'(1);
            visited_in = visited_ff + NW'(1);
            res_in.carved_valid = 1'b1;
            res_in.carved_cell  = 10'(nb_addr);
            state_in   = ST_WALL;
         end
         ST_WALL: begin
            cell_waddr = top_ff;
            if (dir_ff == DIR_E) begin
               cell_we    = 1'b1;
               cell_wdata = nbf_ff[0] | F_EAST;
            end else if (dir_ff == DIR_S) begin
               cell_we    = 1'b1;
               cell_wdata = nbf_ff[0] | F_SOUTH;
            end
            state_in = ST_TR_RD;
         end
         ST_TR_RD: begin
            state_in = cursor_vld_ff ? ST_TR_PAR : ST_RESP;
         end
         ST_TR_PAR: begin
            cell_raddr = par_rd_ff[CW-1:0];
            if (par_rd_ff[CW]) begin
               cursor_in = par_rd_ff[CW-1:0];
               state_in  = ST_TR_MARK;
            end else begin
               cursor_vld_in = 1'b0;
               state_in      = ST_RESP;
            end
         end
         ST_TR_MARK: begin
            cell_we            = 1'b1;
            cell_waddr         = cursor_ff;
            cell_wdata         = cell_rd_ff | F_TRACE;
            res_in.trace_valid = 1'b1;
            res_in.trace_cell  = 10'(cursor_ff);
            state_in           = ST_RESP;
         end
         ST_CLR_RD: begin
            state_in = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            cell_we    = 1'b1;
            cell_wdata = cell_rd_ff & ~F_TRACE;
            cnt_in     = cnt_ff + CW'(1);
            state_in   = (cnt_ff == CW'(NCELLS - 1)) ? ST_RESP : ST_CLR_RD;
         end
         ST_ITEM_CAP: begin
            cell_waddr = CW'(idx_ff);
            cell_wdata = cell_rd_ff | F_TRACE;
            if (kind_ff == KIND_TRACE) begin
               cell_we            = 1'b1;
               cursor_in          = CW'(idx_ff);
               cursor_vld_in      = 1'b1;
               res_in.trace_valid = 1'b1;
               res_in.trace_cell  = idx_ff;
            end else begin
               res_in.cell_flags = cell_rd_ff;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         depth_ff      <= '0;
         visited_ff    <= '0;
         cursor_vld_ff <= 1'b0;
         lfsr_ff       <= SEED_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         depth_ff      <= depth_in;
         visited_ff    <= visited_in;
         cursor_vld_ff <= cursor_vld_in;
         lfsr_ff       <= lfsr_in;
      end
      kind_ff   <= kind_in;
      idx_ff    <= idx_in;
      geo_w_ff  <= geo_w_in;
      geo_h_ff  <= geo_h_in;
      cells_ff  <= cells_in;
      cursor_ff <= cursor_in;
      top_ff    <= top_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      cand_ff   <= cand_in;
      nbf_ff    <= nbf_in;
      dir_ff    <= dir_in;
      slot_ff   <= slot_in;
      res_ff    <= res_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_waddr] <= par_wdata;
      end
      par_rd_ff <= par_mem[par_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   always_comb begin
      rsp_strobe        = state_ff == ST_RESP;
      rsp_data          = res_ff;
      rsp_data.finished = visited_ff >= cells_ff;
   end

   `MDB_ASSERT(a_depth_bound, clock, reset, 32'(depth_ff) <= NCELLS)
   `MDB_ASSERT(a_visited_bound, clock, reset, 32'(visited_ff) <= NCELLS)
   `MDB_ASSERT_IMP(a_carve_candidate, clock, reset, state_ff == ST_CARVE, cand_ff[dir_ff])
   `MDB_ASSERT_NXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe)

endmodule
